FILE: rtl/core/urt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urt_pkg
// shared widths, codes, reset values and controller/datapath bundles
// ----------------------------------------------------------------------------
package urt_pkg;

   localparam int MAX_REGIONS_DEF = 64;
   localparam int PAGE_BYTES_DEF  = 4096;

   localparam int ADDR_W     = 64;
   localparam int LEN_W      = 64;
   localparam int VA_W       = 48;
   localparam int END_W      = 49;
   localparam int COMMIT_W   = 24;
   localparam int PROT_W     = 5;
   localparam int STATUS_W   = 3;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 48;
   localparam int WALK_W     = 50;

   localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PROBE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NORES    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_CONFLICT = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DENIED   = 3'd4;

   localparam logic [PROT_W-1:0] PROT_WRITABLE = 5'h12;
   localparam logic [PROT_W-1:0] PROT_ANY      = 5'h1F;

   localparam logic [CSR_IDX_W-1:0] CSR_CANONICAL_TOP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COMMIT_LIMIT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COPY_LIMIT    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_BASE     = 2'd3;

   localparam logic [VA_W-1:0]     TOP_RESET   = 48'h7FFF_FFFF_FFFF;
   localparam logic [COMMIT_W-1:0] LIMIT_RESET = 24'd8192;
   localparam logic [VA_W-1:0]     COPY_RESET  = 48'd1048576;
   localparam logic [VA_W-1:0]     HEAP_RESET  = 48'h0000_1000_0000;

   typedef struct packed {
      logic                capture;
      logic                prep;
      logic                check;
      logic                scan_clr;
      logic                rd;
      logic                idx_inc;
      logic                st_ld;
      logic [STATUS_W-1:0] st_code;
      logic                commit;
      logic                advance;
      logic                free_hit;
      logic                move_rd;
      logic                move_wr;
      logic                load_out;
   } cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic                chk_fail;
      logic [STATUS_W-1:0] chk_code;
      logic                deny;
      logic                walk_done;
      logic                scan_end;
      logic                hit;
      logic                prot_ok;
      logic                out_free;
   } sts_type;

endpackage
`default_nettype wire

FILE: rtl/core/urt_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urt channel interfaces
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface urt_req_if;
   logic                         valid;
   logic                         ready;
   logic [urt_pkg::MODE_W-1:0]   mode;
   logic [urt_pkg::ADDR_W-1:0]   address;
   logic [urt_pkg::LEN_W-1:0]    length;
   logic [urt_pkg::PROT_W-1:0]   prot;
   logic                         write;
   modport source (output valid, mode, address, length, prot, write, input ready);
   modport sink   (input valid, mode, address, length, prot, write, output ready);
endinterface

interface urt_rsp_if #(
   parameter int CW = $clog2(urt_pkg::MAX_REGIONS_DEF + 1)
);
   logic                          valid;
   logic                          ready;
   logic [urt_pkg::STATUS_W-1:0]  status;
   logic [urt_pkg::VA_W-1:0]      base_out;
   logic [CW-1:0]                 regions_used;
   logic [urt_pkg::COMMIT_W-1:0]  pages_committed;
   modport source (output valid, status, base_out, regions_used, pages_committed,
                   input ready);
   modport sink   (input valid, status, base_out, regions_used, pages_committed,
                   output ready);
endinterface
`default_nettype wire

FILE: rtl/core/urt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urt_ctrl
// sequencer for alloc, free and probe over the region table
// ----------------------------------------------------------------------------
module urt_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire urt_pkg::sts_type sts,
   output urt_pkg::cmd_type      cmd
);

   typedef enum logic [8:0] {
      S_IDLE    = 9'b0_0000_0001,
      S_PREP    = 9'b0_0000_0010,
      S_CHECK   = 9'b0_0000_0100,
      S_RD      = 9'b0_0000_1000,
      S_CMP     = 9'b0_0001_0000,
      S_WALK    = 9'b0_0010_0000,
      S_MOVE_RD = 9'b0_0100_0000,
      S_MOVE_WR = 9'b0_1000_0000,
      S_DONE    = 9'b1_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            priority if (sts.mode == urt_pkg::MODE_ALLOC) begin
               if (sts.chk_fail) begin
                  cmd.st_ld   = 1'b1;
                  cmd.st_code = sts.chk_code;
                  state_in    = S_DONE;
               end else begin
                  cmd.scan_clr = 1'b1;
                  state_in     = S_RD;
               end
            end else if (sts.mode == urt_pkg::MODE_FREE) begin
               cmd.scan_clr = 1'b1;
               state_in     = S_RD;
            end else if (sts.mode == urt_pkg::MODE_PROBE) begin
               if (sts.deny) begin
                  cmd.st_ld   = 1'b1;
                  cmd.st_code = urt_pkg::ST_DENIED;
                  state_in    = S_DONE;
               end else if (sts.walk_done) begin
                  cmd.st_ld   = 1'b1;
                  cmd.st_code = urt_pkg::ST_OK;
                  state_in    = S_DONE;
               end else begin
                  cmd.scan_clr = 1'b1;
                  state_in     = S_RD;
               end
            end else begin
               cmd.st_ld   = 1'b1;
               cmd.st_code = urt_pkg::ST_INVALID;
               state_in    = S_DONE;
            end
         end
         S_RD: begin
            if (sts.scan_end) begin
               cmd.st_ld = 1'b1;
               state_in  = S_DONE;
               priority if (sts.mode == urt_pkg::MODE_ALLOC) begin
                  cmd.commit  = 1'b1;
                  cmd.st_code = urt_pkg::ST_OK;
               end else if (sts.mode == urt_pkg::MODE_FREE) begin
                  cmd.st_code = urt_pkg::ST_INVALID;
               end else begin
                  cmd.st_code = urt_pkg::ST_DENIED;
               end
            end else begin
               cmd.rd   = 1'b1;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (!sts.hit) begin
               cmd.idx_inc = 1'b1;
               state_in    = S_RD;
            end else begin
               priority if (sts.mode == urt_pkg::MODE_ALLOC) begin
                  cmd.st_ld   = 1'b1;
                  cmd.st_code = urt_pkg::ST_CONFLICT;
                  state_in    = S_DONE;
               end else if (sts.mode == urt_pkg::MODE_FREE) begin
                  cmd.free_hit = 1'b1;
                  state_in     = S_MOVE_RD;
               end else if (!sts.prot_ok) begin
                  cmd.st_ld   = 1'b1;
                  cmd.st_code = urt_pkg::ST_DENIED;
                  state_in    = S_DONE;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = S_WALK;
               end
            end
         end
         S_WALK: begin
            if (sts.walk_done) begin
               cmd.st_ld   = 1'b1;
               cmd.st_code = urt_pkg::ST_OK;
               state_in    = S_DONE;
            end else begin
               cmd.scan_clr = 1'b1;
               state_in     = S_RD;
            end
         end
         S_MOVE_RD: begin
            cmd.move_rd = 1'b1;
            state_in    = S_MOVE_WR;
         end
         S_MOVE_WR: begin
            cmd.move_wr = 1'b1;
            cmd.st_ld   = 1'b1;
            cmd.st_code = urt_pkg::ST_OK;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

FILE: rtl/core/urt_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urt_datapath
// region table memory, counters, config registers and result register
// ----------------------------------------------------------------------------
module urt_datapath #(
   parameter int MAX_REGIONS = urt_pkg::MAX_REGIONS_DEF,
   parameter int PAGE_BYTES  = urt_pkg::PAGE_BYTES_DEF,
   parameter int CW          = $clog2(MAX_REGIONS + 1)
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire urt_pkg::cmd_type                 cmd,
   output urt_pkg::sts_type                      sts,
   input  wire logic [urt_pkg::MODE_W-1:0]       req_mode,
   input  wire logic [urt_pkg::ADDR_W-1:0]       req_address,
   input  wire logic [urt_pkg::LEN_W-1:0]        req_length,
   input  wire logic [urt_pkg::PROT_W-1:0]       req_prot,
   input  wire logic                             req_write,
   input  wire logic                             csr_we,
   input  wire logic [urt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [urt_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [urt_pkg::STATUS_W-1:0]          rsp_status,
   output logic [urt_pkg::VA_W-1:0]              rsp_base_out,
   output logic [CW-1:0]                         rsp_regions_used,
   output logic [urt_pkg::COMMIT_W-1:0]          rsp_pages_committed
);

   localparam int PS   = $clog2(PAGE_BYTES);
   localparam int IW   = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int PGW  = urt_pkg::LEN_W - PS + 1;
   localparam int SZW  = urt_pkg::COMMIT_W + 1 + PS;
   localparam int FW   = urt_pkg::END_W - PS;
   localparam int AW   = urt_pkg::ADDR_W;
   localparam int PW   = urt_pkg::WALK_W;
   localparam int EW   = urt_pkg::END_W;
   localparam int VW   = urt_pkg::VA_W;
   localparam int KW   = urt_pkg::COMMIT_W;
   localparam logic [PW-1:0] OFS_BITS = PW'(PAGE_BYTES - 1);

   // table storage
   logic [VW-1:0]              mem_start [MAX_REGIONS];
   logic [EW-1:0]              mem_end   [MAX_REGIONS];
   logic [urt_pkg::PROT_W-1:0] mem_prot  [MAX_REGIONS];

   logic [VW-1:0]              rd_start_ff;
   logic [EW-1:0]              rd_end_ff;
   logic [urt_pkg::PROT_W-1:0] rd_prot_ff;

   logic [urt_pkg::MODE_W-1:0] mode_ff;
   logic [AW-1:0]              addr_ff;
   logic [urt_pkg::LEN_W-1:0]  len_ff;
   logic [urt_pkg::PROT_W-1:0] prot_ff;
   logic                       wr_ff;
   logic [PGW-1:0]             pages_ff;
   logic [AW-1:0]              va_ff;
   logic                       deny_ff;
   logic [PW-1:0]              p_ff;
   logic [PW-1:0]              end_ff;
   logic [EW-1:0]              vend_ff;
   logic [CW-1:0]              idx_ff;
   logic [IW-1:0]              hit_ff;
   logic [FW-1:0]              fpages_ff;
   logic [CW-1:0]              count_ff;
   logic [KW-1:0]              committed_ff;
   logic [EW-1:0]              heap_ff;
   logic [VW-1:0]              top_ff;
   logic [KW-1:0]              climit_ff;
   logic [VW-1:0]              copy_ff;
   logic [urt_pkg::STATUS_W-1:0] status_ff;
   logic [VW-1:0]              base_ff;

   logic                         out_valid_ff;
   logic [urt_pkg::STATUS_W-1:0] out_status_ff;
   logic [VW-1:0]                out_base_ff;
   logic [CW-1:0]                out_count_ff;
   logic [KW-1:0]                out_committed_ff;

   logic [PGW-1:0]             pages_c;
   logic [AW-1:0]              va_c;
   logic                       deny_c;
   logic [SZW-1:0]             size_c;
   logic [AW-1:0]              vlast_c;
   logic [KW:0]                csum_c;
   logic [EW-1:0]              vend_c;
   logic                       chk_fail_c;
   logic [urt_pkg::STATUS_W-1:0] chk_code_c;
   logic                       hit_c;
   logic [urt_pkg::PROT_W-1:0] need_c;
   logic                       mem_we;
   logic [IW-1:0]              mem_wa;
   logic [VW-1:0]              mem_ws;
   logic [EW-1:0]              mem_wend;
   logic [urt_pkg::PROT_W-1:0] mem_wp;
   logic                       mem_re;
   logic [IW-1:0]              mem_ra;
   logic [CW-1:0]              last_c;

   // operand preparation
   assign pages_c = PGW'(len_ff >> PS) + PGW'(|len_ff[PS-1:0]);
   assign va_c    = (addr_ff == '0) ? AW'(heap_ff) : addr_ff;
   assign deny_c  = (addr_ff > AW'(top_ff)) || (len_ff > urt_pkg::LEN_W'(copy_ff));

   // alloc admission checks
   assign size_c  = SZW'(pages_ff[KW:0]) << PS;
   assign vlast_c = va_ff + AW'(size_c) - AW'(1);
   assign csum_c  = {1'b0, committed_ff} + pages_ff[KW:0];
   assign vend_c  = va_ff[EW-1:0] + EW'(size_c);

   always_comb begin
      chk_fail_c = 1'b1;
      chk_code_c = urt_pkg::ST_OK;
      priority if (len_ff == '0) begin
         chk_code_c = urt_pkg::ST_INVALID;
      end else if (pages_ff > PGW'(climit_ff)) begin
         chk_code_c = urt_pkg::ST_NORES;
      end else if ((va_ff > AW'(top_ff)) || (vlast_c > AW'(top_ff))) begin
         chk_code_c = urt_pkg::ST_CONFLICT;
      end else if (count_ff >= CW'(MAX_REGIONS)) begin
         chk_code_c = urt_pkg::ST_NORES;
      end else if (csum_c > {1'b0, climit_ff}) begin
         chk_code_c = urt_pkg::ST_NORES;
      end else begin
         chk_fail_c = 1'b0;
      end
   end

   // per-entry compare
   assign need_c = wr_ff ? urt_pkg::PROT_WRITABLE : urt_pkg::PROT_ANY;
   always_comb begin
      priority if (mode_ff == urt_pkg::MODE_ALLOC) begin
         hit_c = (va_ff[EW-1:0] < rd_end_ff) && (vend_ff > EW'(rd_start_ff));
      end else if (mode_ff == urt_pkg::MODE_FREE) begin
         hit_c = (addr_ff == AW'(rd_start_ff));
      end else begin
         hit_c = (p_ff >= PW'(rd_start_ff)) && (p_ff < PW'(rd_end_ff));
      end
   end

   assign sts.mode      = mode_ff;
   assign sts.chk_fail  = chk_fail_c;
   assign sts.chk_code  = chk_code_c;
   assign sts.deny      = deny_ff;
   assign sts.walk_done = (p_ff >= end_ff);
   assign sts.scan_end  = (idx_ff >= count_ff);
   assign sts.hit       = hit_c;
   assign sts.prot_ok   = ((rd_prot_ff & need_c) != '0);
   assign sts.out_free  = !out_valid_ff || rsp_ready;

   // memory ports
   assign last_c   = count_ff - CW'(1);
   assign mem_re   = cmd.rd || cmd.move_rd;
   assign mem_ra   = cmd.move_rd ? last_c[IW-1:0] : idx_ff[IW-1:0];
   assign mem_we   = cmd.commit || cmd.move_wr;
   assign mem_wa   = cmd.commit ? count_ff[IW-1:0] : hit_ff;
   assign mem_ws   = cmd.commit ? va_ff[VW-1:0] : rd_start_ff;
   assign mem_wend = cmd.commit ? vend_ff : rd_end_ff;
   assign mem_wp   = cmd.commit ? prot_ff : rd_prot_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_start[mem_wa] <= mem_ws;
         mem_end[mem_wa]   <= mem_wend;
         mem_prot[mem_wa]  <= mem_wp;
      end
      if (mem_re) begin
         rd_start_ff <= mem_start[mem_ra];
         rd_end_ff   <= mem_end[mem_ra];
         rd_prot_ff  <= mem_prot[mem_ra];
      end
   end

   // operation payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         addr_ff <= req_address;
         len_ff  <= req_length;
         prot_ff <= req_prot;
         wr_ff   <= req_write;
         base_ff <= '0;
      end
      if (cmd.prep) begin
         pages_ff <= pages_c;
         va_ff    <= va_c;
         deny_ff  <= deny_c;
         p_ff     <= {addr_ff[PW-1:PS], PS'(0)};
         end_ff   <= addr_ff[PW-1:0] + len_ff[PW-1:0];
      end
      if (cmd.check) begin
         vend_ff <= vend_c;
      end
      if (cmd.scan_clr) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + CW'(1);
      end
      if (cmd.advance) begin
         p_ff <= (PW'(rd_end_ff) + OFS_BITS) & ~OFS_BITS;
      end
      if (cmd.free_hit) begin
         hit_ff    <= idx_ff[IW-1:0];
         fpages_ff <= FW'((rd_end_ff - EW'(rd_start_ff)) >> PS);
      end
      if (cmd.st_ld) begin
         status_ff <= cmd.st_code;
      end
      if (cmd.commit) begin
         base_ff <= va_ff[VW-1:0];
      end
   end

   // table state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         committed_ff <= '0;
         heap_ff      <= EW'(urt_pkg::HEAP_RESET);
         top_ff       <= urt_pkg::TOP_RESET;
         climit_ff    <= urt_pkg::LIMIT_RESET;
         copy_ff      <= urt_pkg::COPY_RESET;
      end else begin
         if (cmd.commit) begin
            count_ff     <= count_ff + CW'(1);
            committed_ff <= csum_c[KW-1:0];
            if (addr_ff == '0) begin
               heap_ff <= vend_ff;
            end
         end else if (cmd.move_wr) begin
            count_ff <= last_c;
            if (FW'(committed_ff) >= fpages_ff) begin
               committed_ff <= committed_ff - fpages_ff[KW-1:0];
            end else begin
               committed_ff <= '0;
            end
         end
         if (csr_we) begin
            unique case (csr_index)
               urt_pkg::CSR_CANONICAL_TOP: top_ff    <= csr_wdata;
               urt_pkg::CSR_COMMIT_LIMIT:  climit_ff <= csr_wdata[KW-1:0];
               urt_pkg::CSR_COPY_LIMIT:    copy_ff   <= csr_wdata;
               urt_pkg::CSR_HEAP_BASE:     heap_ff   <= EW'(csr_wdata);
               default: begin
               end
            endcase
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_status_ff    <= status_ff;
         out_base_ff      <= base_ff;
         out_count_ff     <= count_ff;
         out_committed_ff <= committed_ff;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_status          = out_status_ff;
   assign rsp_base_out        = out_base_ff;
   assign rsp_regions_used    = out_count_ff;
   assign rsp_pages_committed = out_committed_ff;

endmodule
`default_nettype wire

FILE: rtl/core/user_region_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// user_region_table
// bounded table of user address regions with commit count and heap break
// ----------------------------------------------------------------------------
// One request is in flight at a time. The table sits in a memory with one
// read port and registered read data, so every entry visited costs a read
// state and a compare state. An alloc scans all live entries unless one
// overlaps, a free scans up to the matching entry and then moves the last
// entry into the hole, and a probe scans once for every region its byte
// range crosses, with a walk step after each crossing. A finished response
// waits in an output register while the next request is accepted.
// Configuration writes are taken in any cycle.
module user_region_table #(
   parameter int MAX_REGIONS = urt_pkg::MAX_REGIONS_DEF,
   parameter int PAGE_BYTES  = urt_pkg::PAGE_BYTES_DEF,
   parameter int CW          = $clog2(MAX_REGIONS + 1)
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   urt_req_if.sink                             req,
   urt_rsp_if.source                           rsp,
   input  wire logic                           csr_we,
   input  wire logic [urt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [urt_pkg::CSR_DATA_W-1:0] csr_wdata
);

   urt_pkg::cmd_type cmd;
   urt_pkg::sts_type sts;
   logic             ready;
   logic [CW-1:0]    regions_used;

   urt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   urt_datapath #(
      .MAX_REGIONS (MAX_REGIONS),
      .PAGE_BYTES  (PAGE_BYTES),
      .CW          (CW)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_mode            (req.mode),
      .req_address         (req.address),
      .req_length          (req.length),
      .req_prot            (req.prot),
      .req_write           (req.write),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_valid           (rsp.valid),
      .rsp_ready           (rsp.ready),
      .rsp_status          (rsp.status),
      .rsp_base_out        (rsp.base_out),
      .rsp_regions_used    (regions_used),
      .rsp_pages_committed (rsp.pages_committed)
   );

   assign req.ready        = ready;
   assign rsp.regions_used = regions_used;

endmodule
`default_nettype wire

FILE: rtl/core/urt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urt_checker
// port-level checks for user_region_table, bound to the top level
// ----------------------------------------------------------------------------
module urt_checker #(
   parameter int MAX_REGIONS = urt_pkg::MAX_REGIONS_DEF,
   parameter int CW          = $clog2(MAX_REGIONS + 1)
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [urt_pkg::STATUS_W-1:0]  rsp_status,
   input wire logic [urt_pkg::VA_W-1:0]      rsp_base_out,
   input wire logic [CW-1:0]                 rsp_regions_used
);

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response beat changed while stalled");

   // one request at a time
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request accepted during an operation");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= urt_pkg::ST_DENIED)
      else $error("undefined status code");

   a_base_on_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != urt_pkg::ST_OK |-> rsp_base_out == '0)
      else $error("base given on a failed operation");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_regions_used <= CW'(MAX_REGIONS))
      else $error("region count above table size");

endmodule

bind user_region_table urt_checker #(
   .MAX_REGIONS (MAX_REGIONS),
   .CW          (CW)
) u_urt_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_status       (rsp.status),
   .rsp_base_out     (rsp.base_out),
   .rsp_regions_used (rsp.regions_used)
);
`default_nettype wire
